[src/nbc_pkg.sv]
//------------------------------------------------------------------------------
// nbc_pkg: shared types and constants for the naive Bayes classifier
// Holds default sizes, request codes, controller states, the command/status
// structs and the fixed-point log2 function.
//------------------------------------------------------------------------------
`default_nettype none
package nbc_pkg;

    localparam int DEF_MAX_FEATURES = 16;
    localparam int DEF_VALUE_LEVELS = 16;
    localparam int DEF_MAX_CLASSES  = 4;
    localparam int DEF_COUNT_WIDTH  = 16;

    localparam int FUNC_W  = 2;
    localparam int FIDX_W  = 4;
    localparam int VAL_W   = 4;
    localparam int LABEL_W = 2;
    localparam int NF_W    = 5;
    localparam int NC_W    = 3;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    // Score accumulator: log2q of values up to 2^33 fits in 14 bits, and up to
    // 64 feature terms plus the prior are summed.
    localparam int LOGQ_W  = 14;
    localparam int SCORE_W = 22;

    localparam logic [FUNC_W-1:0] FUNC_TRAIN = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TEST  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    localparam logic [ADDR_W-1:0] REG_NUM_FEATURES = 3'd0;
    localparam logic [ADDR_W-1:0] REG_NUM_CLASSES  = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_TRAIN_WR,
        ST_CLS_START,
        ST_CLS_RD,
        ST_CLS_ACC,
        ST_CLS_NEXT,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic clear_start;   // reset sweep address, clear row counts
        logic clear_step;    // write zero at sweep address
        logic train_read;    // read count cell and distinct count of item
        logic train_write;   // write back incremented counts
        logic test_store;    // store test value
        logic cls_init;      // start the class walk
        logic cls_acc;       // add the feature term
        logic cls_next;      // close class, compare, step to next class
        logic res_load;      // load the result register
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic feat_last;
        logic class_last;
        logic out_busy;
    } stat_t;

    // 256*floor(log2 x) + 8 bits after the leading one; x = 0 gives 0.
    function automatic logic [LOGQ_W-1:0] log2q(input logic [33:0] x);
        logic [5:0]  p;
        logic [41:0] sh;
        begin
            p = '0;
            for (int i = 0; i < 34; i++)
                if (x[i]) p = 6'(i);
            sh = {x, 8'd0} >> p;
            log2q = (x == '0) ? '0 : LOGQ_W'({p, sh[7:0]});
        end
    endfunction

endpackage
`default_nettype wire

[src/nbc_ram.sv]
//------------------------------------------------------------------------------
// nbc_ram: generic single-port RAM
// One write or read per cycle, registered read data.
//------------------------------------------------------------------------------
`default_nettype none
module nbc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

[src/nbc_ctrl.sv]
//------------------------------------------------------------------------------
// nbc_ctrl: request sequencer
// Decodes each accepted request and steps the datapath through training,
// clearing and classification.
//------------------------------------------------------------------------------
`default_nettype none
module nbc_ctrl
    import nbc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [FUNC_W-1:0] func,
    input  wire logic              train_ok,
    input  wire logic              last,
    input  wire stat_t             stat,
    output cmd_t                   cmd
);
    state_t state_reg, state_next;
    logic   accept;

    assign accept = in_valid && !in_stall;

    // Reset starts with a sweep that zeroes the count memory.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        FUNC_TRAIN: if (train_ok) state_next = ST_TRAIN_WR;
                        FUNC_CLEAR: state_next = ST_CLEAR;
                        FUNC_TEST:  if (last) state_next = ST_CLS_START;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR:     if (stat.clear_done) state_next = ST_IDLE;
            ST_TRAIN_WR:  state_next = ST_IDLE;
            ST_CLS_START: state_next = ST_CLS_RD;
            ST_CLS_RD:    state_next = ST_CLS_ACC;
            ST_CLS_ACC:   state_next = stat.feat_last ? ST_CLS_NEXT : ST_CLS_RD;
            ST_CLS_NEXT:  state_next = stat.class_last ? ST_RESULT : ST_CLS_RD;
            ST_RESULT:    if (!stat.out_busy) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                cmd.clear_start = accept && (func == FUNC_CLEAR);
                cmd.train_read  = accept && (func == FUNC_TRAIN) && train_ok;
                cmd.test_store  = accept && (func == FUNC_TEST);
            end
            ST_CLEAR:     cmd.clear_step  = 1'b1;
            ST_TRAIN_WR:  cmd.train_write = 1'b1;
            ST_CLS_START: cmd.cls_init    = 1'b1;
            ST_CLS_ACC:   cmd.cls_acc     = 1'b1;
            ST_CLS_NEXT:  cmd.cls_next    = 1'b1;
            ST_RESULT:    cmd.res_load    = !stat.out_busy;
            default:      cmd = '0;
        endcase
    end

`ifndef SYNTHESIS
    a_train_pair: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TRAIN_WR |=> state_reg == ST_IDLE)
        else $error("train write not followed by idle");
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> in_stall)
        else $error("request taken while busy");
    a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |=> state_reg == ST_IDLE)
        else $error("result loaded without return to idle");
`endif
endmodule
`default_nettype wire

[src/nbc_datapath.sv]
//------------------------------------------------------------------------------
// nbc_datapath: count memories, score accumulator and result register
// Holds all training state and walks the score terms one feature at a time.
//------------------------------------------------------------------------------
`default_nettype none
module nbc_datapath
    import nbc_pkg::*;
#(
    parameter int MAX_FEATURES = DEF_MAX_FEATURES,
    parameter int VALUE_LEVELS = DEF_VALUE_LEVELS,
    parameter int MAX_CLASSES  = DEF_MAX_CLASSES,
    parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    output stat_t                   stat,
    input  wire logic [FIDX_W-1:0]  feature_index,
    input  wire logic [VAL_W-1:0]   value,
    input  wire logic [LABEL_W-1:0] label,
    input  wire logic               last,
    input  wire logic [NF_W-1:0]    num_features,
    input  wire logic [NC_W-1:0]    num_classes,
    output logic                    train_ok,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [LABEL_W-1:0]      predicted_class,
    output logic                    no_training
);
    localparam int CW    = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int FW    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int VW    = $clog2(VALUE_LEVELS);
    localparam int PAIRS = MAX_CLASSES * MAX_FEATURES;
    localparam int CELLS = PAIRS * VALUE_LEVELS;
    localparam int PW    = $clog2(PAIRS);
    localparam int AW    = $clog2(CELLS);
    localparam int DW    = $clog2(VALUE_LEVELS + 1);
    localparam int SW    = AW + 1;
    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    logic [SW-1:0]          sweep_reg;
    logic [PAIRS-1:0]       pvalid_reg;   // distinct entry written since clear
    logic [COUNT_WIDTH-1:0] rows_reg [MAX_CLASSES];
    logic [VW-1:0]          test_reg [MAX_FEATURES];
    logic [CW-1:0]          lab_reg, cls_reg, best_reg;
    logic [FW-1:0]          fi_reg, feat_reg;
    logic [VW-1:0]          val_reg;
    logic                   last_reg, found_reg;
    logic [SCORE_W-1:0]     score_reg, best_score_reg;
    logic                   out_valid_reg, out_nt_reg;
    logic [LABEL_W-1:0]     out_cls_reg;

    logic [NF_W-1:0] nf_eff;
    logic [NC_W:0]   nc_eff;
    assign nf_eff = (num_features == '0) ? NF_W'(1) :
                    (32'(num_features) > MAX_FEATURES) ? NF_W'(MAX_FEATURES) : num_features;
    assign nc_eff = (num_classes == '0) ? (NC_W+1)'(1) :
                    (32'(num_classes) > MAX_CLASSES) ? (NC_W+1)'(MAX_CLASSES) :
                    {1'b0, num_classes};

    assign train_ok = (32'(label) < MAX_CLASSES) && (32'(feature_index) < MAX_FEATURES)
                      && (32'(value) < VALUE_LEVELS);

    // Memory addressing.
    logic [PW-1:0]          pair_addr;
    logic [AW-1:0]          cell_addr;
    logic                   cnt_we, dv_we;
    logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata;
    logic [DW-1:0]          dv_wdata, dv_rdata, dv_eff;
    logic                   clearing;

    assign clearing = cmd.clear_step;

    always_comb
    begin
        if (cmd.train_read)
            pair_addr = PW'(32'(label) * MAX_FEATURES + 32'(feature_index));
        else if (cmd.train_write)
            pair_addr = PW'(32'(lab_reg) * MAX_FEATURES + 32'(fi_reg));
        else
            pair_addr = PW'(32'(cls_reg) * MAX_FEATURES + 32'(feat_reg));
        if (clearing)
            cell_addr = sweep_reg[AW-1:0];
        else if (cmd.train_read)
            cell_addr = AW'(32'(pair_addr) * VALUE_LEVELS + 32'(value));
        else if (cmd.train_write)
            cell_addr = AW'(32'(pair_addr) * VALUE_LEVELS + 32'(val_reg));
        else
            cell_addr = AW'(32'(pair_addr) * VALUE_LEVELS + 32'(test_reg[feat_reg]));
    end

    assign dv_eff    = pvalid_reg[pair_addr] ? dv_rdata : '0;
    assign cnt_we    = clearing || cmd.train_write;
    assign cnt_wdata = clearing ? '0 : ((cnt_rdata == CMAX) ? CMAX : cnt_rdata + 1'b1);
    assign dv_we     = cmd.train_write;
    assign dv_wdata  = (cnt_rdata == '0 && 32'(dv_eff) < VALUE_LEVELS) ? dv_eff + 1'b1
                                                                        : dv_eff;

    nbc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(CELLS)) u_counts (
        .clk(clk), .we(cnt_we), .addr(cell_addr), .wdata(cnt_wdata), .rdata(cnt_rdata));
    nbc_ram #(.WIDTH(DW), .DEPTH(PAIRS)) u_distinct (
        .clk(clk), .we(dv_we), .addr(pair_addr), .wdata(dv_wdata), .rdata(dv_rdata));

    // Score terms. Both memories return the entry of the current (class,
    // feature) in the accumulate cycle, so both logs are taken there.
    logic [COUNT_WIDTH-1:0] d_cur;
    logic [LOGQ_W-1:0]      n_log;
    logic [LOGQ_W-1:0]      dk_log;
    logic [SCORE_W-1:0]     score_fin;
    assign d_cur     = rows_reg[cls_reg];
    assign n_log     = log2q(34'(cnt_rdata) + 34'd1);
    assign dk_log    = log2q(34'(d_cur) + 34'(dv_eff));
    assign score_fin = score_reg;

    assign stat.clear_done = (sweep_reg == SW'(CELLS - 1));
    assign stat.feat_last  = (32'(feat_reg) + 1 >= 32'(nf_eff));
    assign stat.class_last = (32'(cls_reg) + 1 >= 32'(nc_eff));
    assign stat.out_busy   = out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg     <= '0;
            pvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_CLASSES; i++) rows_reg[i] <= '0;
            for (int i = 0; i < MAX_FEATURES; i++) test_reg[i] <= '0;
        end
        else
        begin
            if (cmd.res_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (cmd.clear_start)
            begin
                sweep_reg  <= '0;
                pvalid_reg <= '0;
                for (int i = 0; i < MAX_CLASSES; i++) rows_reg[i] <= '0;
            end
            if (cmd.clear_step)
                sweep_reg <= sweep_reg + 1'b1;
            if (cmd.train_write)
            begin
                pvalid_reg[pair_addr] <= 1'b1;
                if (last_reg)
                    rows_reg[lab_reg] <= (rows_reg[lab_reg] == CMAX) ? CMAX
                                         : rows_reg[lab_reg] + 1'b1;
            end
            if (cmd.test_store && 32'(feature_index) < MAX_FEATURES
                && 32'(value) < VALUE_LEVELS)
                test_reg[FW'(feature_index)] <= VW'(value);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.train_read)
        begin
            lab_reg  <= CW'(label);
            fi_reg   <= FW'(feature_index);
            val_reg  <= VW'(value);
            last_reg <= last;
        end
        if (cmd.cls_init)
        begin
            cls_reg   <= '0;
            feat_reg  <= '0;
            found_reg <= 1'b0;
            best_reg  <= '0;
            score_reg <= SCORE_W'(log2q(34'(rows_reg[0])));
        end
        if (cmd.cls_acc)
        begin
            score_reg <= score_reg + SCORE_W'(n_log) - SCORE_W'(dk_log);
            if (!stat.feat_last)
                feat_reg <= feat_reg + 1'b1;
        end
        if (cmd.cls_next)
        begin
            if (d_cur != '0 && (!found_reg || $signed(score_fin) > $signed(best_score_reg)))
            begin
                found_reg      <= 1'b1;
                best_reg       <= cls_reg;
                best_score_reg <= score_fin;
            end
            feat_reg <= '0;
            if (!stat.class_last)
            begin
                cls_reg   <= cls_reg + 1'b1;
                score_reg <= SCORE_W'(log2q(34'(rows_reg[cls_reg + 1'b1])));
            end
        end
        if (cmd.res_load)
        begin
            out_cls_reg <= found_reg ? LABEL_W'(best_reg) : '0;
            out_nt_reg  <= !found_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign predicted_class = out_cls_reg;
    assign no_training     = out_nt_reg;

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(out_cls_reg))
        else $error("result changed while stalled");
    a_clear_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_step |-> 32'(sweep_reg) < CELLS)
        else $error("clear sweep overran");
    a_nt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_nt_reg |-> out_cls_reg == '0)
        else $error("class given without training");
`endif
endmodule
`default_nettype wire

[src/naive_bayes_categorical_classifier_top.sv]
//------------------------------------------------------------------------------
// naive_bayes_categorical_classifier_top: categorical naive Bayes classifier
// Trains add-one smoothed counts and picks the best class in log2 fixed point.
//------------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | func, feature_index, value, label, last
//  out     | output    | out_valid/out_stall| predicted_class, no_training
//  apb     | input     | psel/penable/pready| paddr, pwdata, prdata
//
// A training request with train_ok high is accepted with the count memory read,
// then written back. A test request without last only stores its value.
// A classifying request (a test request with last) walks the single count
// memory port once per (class, feature), reading and then adding each term, and
// its result waits while the previous result is still held under out_stall.
// A clear request zeroes all MAX_CLASSES*MAX_FEATURES*VALUE_LEVELS count cells
// (1024 at the defaults); after reset the same sweep runs, with in_stall high.
// The result register holds its result while out_stall is high.
//------------------------------------------------------------------------------
`default_nettype none
module naive_bayes_categorical_classifier_top
    import nbc_pkg::*;
#(
    parameter int MAX_FEATURES = DEF_MAX_FEATURES,
    parameter int VALUE_LEVELS = DEF_VALUE_LEVELS,
    parameter int MAX_CLASSES  = DEF_MAX_CLASSES,
    parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [FUNC_W-1:0]  func,
    input  wire logic [FIDX_W-1:0]  feature_index,
    input  wire logic [VAL_W-1:0]   value,
    input  wire logic [LABEL_W-1:0] label,
    input  wire logic               last,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [LABEL_W-1:0]      predicted_class,
    output logic                    no_training,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready
);
    logic [NF_W-1:0] num_features_reg;
    logic [NC_W-1:0] num_classes_reg;
    cmd_t            cmd;
    stat_t           stat;
    logic            train_ok;

    // Configuration registers: written on the access phase of a write.
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_features_reg <= NF_W'(16);
            num_classes_reg  <= NC_W'(4);
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr)
                REG_NUM_FEATURES: num_features_reg <= pwdata[NF_W-1:0];
                REG_NUM_CLASSES:  num_classes_reg  <= pwdata[NC_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            REG_NUM_FEATURES: prdata = DATA_W'(num_features_reg);
            REG_NUM_CLASSES:  prdata = DATA_W'(num_classes_reg);
            default:          prdata = '0;
        endcase
    end

    // Sequencer decides each step; the datapath owns all training and result storage.
    nbc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .train_ok(train_ok), .last(last), .stat(stat), .cmd(cmd));

    nbc_datapath #(
        .MAX_FEATURES(MAX_FEATURES), .VALUE_LEVELS(VALUE_LEVELS),
        .MAX_CLASSES(MAX_CLASSES), .COUNT_WIDTH(COUNT_WIDTH)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .feature_index(feature_index), .value(value), .label(label), .last(last),
        .num_features(num_features_reg), .num_classes(num_classes_reg),
        .train_ok(train_ok), .out_valid(out_valid), .out_stall(out_stall),
        .predicted_class(predicted_class), .no_training(no_training));

`ifndef SYNTHESIS
    a_cfg_range: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr == REG_NUM_CLASSES |=>
        num_classes_reg == $past(pwdata[NC_W-1:0]))
        else $error("class count write lost");
    a_no_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_stall || $past(in_stall))
        else $error("result without a request");
    a_stall_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && func == FUNC_CLEAR |=> in_stall)
        else $error("clear did not stall input");
`endif
endmodule
`default_nettype wire
